>>> rtl/core/cpbf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the climate panel button block.
// No dependencies; every module of the block imports this package.
package cpbf_pkg;

  localparam int MAX_FAN_LEVEL = 8;
  localparam int FAN_W = 4;
  localparam int TEMP_W = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FAN_W-1:0] FAN_MAX = FAN_W'(MAX_FAN_LEVEL);
  localparam logic [FAN_W-1:0] FAN_MIN = FAN_W'(1);
  localparam logic [TEMP_W-1:0] TEMP_RESET = TEMP_W'(44);
  localparam logic [TEMP_W-1:0] TEMP_CEIL = TEMP_W'(127);

  // Unit state codes; codes 6 and 7 may be held but mean nothing.
  localparam logic [2:0] ST_OFF = 3'd0;
  localparam logic [2:0] ST_AUTO = 3'd1;
  localparam logic [2:0] ST_DEF = 3'd2;
  localparam logic [2:0] ST_SENSOR = 3'd3;
  localparam logic [2:0] ST_DIAG = 3'd4;
  localparam logic [2:0] ST_IGN_OFF = 3'd5;

  localparam logic [2:0] VENT_DEFROST = 3'd4;
  localparam logic [2:0] VENT_FACE = 3'd0;

  // Auto control enable bits.
  localparam int AF_INTAKE = 0;
  localparam int AF_MODE = 1;
  localparam int AF_BLOWER = 2;
  localparam int AF_AC = 3;

  typedef enum logic [3:0] {
    BTN_OFF = 4'd0,
    BTN_AUTO = 4'd1,
    BTN_DEFROST = 4'd2,
    BTN_AC = 4'd3,
    BTN_INTAKE = 4'd4,
    BTN_VENT = 4'd5,
    BTN_FAN_UP = 4'd6,
    BTN_FAN_DOWN = 4'd7,
    BTN_TEMP_UP = 4'd8,
    BTN_TEMP_DOWN = 4'd9,
    BTN_REAR = 4'd10,
    BTN_NONE = 4'd15
  } btn_t;

  typedef enum logic [1:0] {
    REG_FINE_LOW = 2'd0,
    REG_FINE_HIGH = 2'd1,
    REG_SP_TOP = 2'd2,
    REG_SP_BOTTOM = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TEMP_W-1:0] fine_band_low;
    logic [TEMP_W-1:0] fine_band_high;
    logic [TEMP_W-1:0] set_point_top;
    logic [TEMP_W-1:0] set_point_bottom;
  } cfg_t;

  // Push side of the command queue.
  typedef struct packed {
    logic push;
    btn_t cmd;
  } q_wr_t;

  // Pop side of the command queue.
  typedef struct packed {
    logic valid;
    btn_t cmd;
  } q_rd_t;

  // Panel status; first field in the highest bits, unit_state in the lowest.
  typedef struct packed {
    logic [3:0] auto_flags;
    logic mode_segment;
    logic rear_defrost_segment;
    logic rear_defrost_on;
    logic [TEMP_W-1:0] set_point_half;
    logic [2:0] vent_mode;
    logic recirc_on;
    logic [FAN_W-1:0] fan_level;
    logic ac_on;
    logic [2:0] unit_state;
  } status_t;

  localparam int STATUS_W = $bits(status_t);
  localparam int OUT_DATA_W = ((STATUS_W + 7) / 8) * 8;

endpackage

>>> rtl/core/cpbf_front.sv
`timescale 1ns / 1ps
// Front end: takes button items from the input stream and classifies them.
// Depends on cpbf_pkg.
module cpbf_front import cpbf_pkg::*; (
  input  logic       full,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [3:0] button
  output q_wr_t      wr
);

  btn_t cmd;

  // Map raw codes to commands; unused codes become a no-op.
  always_comb begin
    unique case (s_tdata[3:0])
      4'd0:    cmd = BTN_OFF;
      4'd1:    cmd = BTN_AUTO;
      4'd2:    cmd = BTN_DEFROST;
      4'd3:    cmd = BTN_AC;
      4'd4:    cmd = BTN_INTAKE;
      4'd5:    cmd = BTN_VENT;
      4'd6:    cmd = BTN_FAN_UP;
      4'd7:    cmd = BTN_FAN_DOWN;
      4'd8:    cmd = BTN_TEMP_UP;
      4'd9:    cmd = BTN_TEMP_DOWN;
      4'd10:   cmd = BTN_REAR;
      default: cmd = BTN_NONE;
    endcase
  end

  assign s_tready = !full;
  assign wr.push = s_tvalid && !full;
  assign wr.cmd = cmd;

endmodule

>>> rtl/core/cpbf_queue.sv
`timescale 1ns / 1ps
// Short command queue between front end and back end.
// Depends on cpbf_pkg.
module cpbf_queue import cpbf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t wr,
  input  logic  pop,
  output q_rd_t rd,
  output logic  full
);

  btn_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign do_pop = pop && (count != '0);
  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign rd.valid = (count != '0);
  assign rd.cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      slots[wr_ptr] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(wr.push) - QCNT_W'(do_pop);
    end
  end

endmodule

>>> rtl/core/cpbf_back.sv
`timescale 1ns / 1ps
// Back end: unless the output stalls, applies one command per cycle to the panel
// state and registers the resulting status for the output stream. Depends on cpbf_pkg.
module cpbf_back import cpbf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  q_rd_t   rd,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output status_t status
);

  logic [2:0]        unit_mode, unit_mode_next;
  logic [2:0]        saved_mode, saved_mode_next;
  logic              ac, ac_next;
  logic [FAN_W-1:0]  fan, fan_next;
  logic              recirc, recirc_next;
  logic [2:0]        vent, vent_next;
  logic [TEMP_W-1:0] temp, temp_next;
  logic              rear, rear_next;
  logic              seg_rear, seg_rear_next;
  logic              seg_mode, seg_mode_next;
  logic [3:0]        auto_en, auto_en_next;

  logic              can_save, active, in_band;
  logic [TEMP_W:0]   temp_up;

  assign pop = rd.valid && (!out_valid || out_ready);
  assign can_save = (unit_mode != ST_OFF) && (unit_mode != ST_IGN_OFF);
  assign active = (unit_mode <= ST_SENSOR);
  assign in_band = (temp < cfg.fine_band_high) && (temp > cfg.fine_band_low);

  always_comb begin
    unit_mode_next = unit_mode;
    saved_mode_next = saved_mode;
    ac_next = ac;
    fan_next = fan;
    recirc_next = recirc;
    vent_next = vent;
    temp_next = temp;
    rear_next = rear;
    seg_rear_next = seg_rear;
    seg_mode_next = seg_mode;
    auto_en_next = auto_en;
    temp_up = '0;
    unique case (rd.cmd)
      BTN_OFF: begin
        if (unit_mode != ST_IGN_OFF) begin
          if (unit_mode != ST_OFF) begin
            if (can_save) saved_mode_next = unit_mode;
            unit_mode_next = ST_OFF;
          end
          seg_mode_next = 1'b0;
        end
        seg_rear_next = 1'b0;
      end
      BTN_AUTO: begin
        auto_en_next = 4'hF;
        seg_rear_next = 1'b1;
        if (active) begin
          if (can_save) saved_mode_next = unit_mode;
          unit_mode_next = ST_AUTO;
        end
      end
      BTN_DEFROST: begin
        seg_rear_next = 1'b1;
        if (unit_mode == ST_OFF || unit_mode == ST_AUTO || unit_mode == ST_SENSOR) begin
          // Entry from off saves nothing.
          if (can_save) saved_mode_next = unit_mode;
          unit_mode_next = ST_DEF;
          ac_next = 1'b1;
          fan_next = FAN_MAX;
          recirc_next = 1'b0;
          vent_next = VENT_DEFROST;
        end else if (unit_mode == ST_DEF) begin
          // Swap with the saved state.
          saved_mode_next = unit_mode;
          unit_mode_next = saved_mode;
        end
      end
      BTN_AC: begin
        auto_en_next[AF_AC] = 1'b0;
        seg_rear_next = 1'b1;
        if (unit_mode == ST_OFF) begin
          unit_mode_next = saved_mode;
          ac_next = 1'b1;
        end else if (active) begin
          ac_next = !ac;
          if (unit_mode == ST_AUTO) begin
            saved_mode_next = unit_mode;
            unit_mode_next = ST_SENSOR;
          end
        end
      end
      BTN_INTAKE: begin
        auto_en_next[AF_INTAKE] = 1'b0;
        seg_rear_next = 1'b1;
        if (active) begin
          recirc_next = !recirc;
          if (unit_mode == ST_AUTO) begin
            saved_mode_next = unit_mode;
            unit_mode_next = ST_SENSOR;
          end
        end
      end
      BTN_VENT: begin
        auto_en_next[AF_MODE] = 1'b0;
        seg_rear_next = 1'b1;
        if (active) begin
          if (vent < VENT_DEFROST) vent_next = vent + 3'd1;
          else if (vent == VENT_DEFROST) vent_next = VENT_FACE;
          if (unit_mode == ST_OFF) begin
            seg_mode_next = 1'b1;
          end else if (unit_mode == ST_AUTO || unit_mode == ST_DEF) begin
            saved_mode_next = unit_mode;
            unit_mode_next = ST_SENSOR;
          end
        end
      end
      BTN_FAN_UP, BTN_FAN_DOWN: begin
        seg_rear_next = 1'b1;
        if (unit_mode == ST_OFF) begin
          fan_next = FAN_MIN;
          unit_mode_next = saved_mode;
        end else if (active) begin
          if (rd.cmd == BTN_FAN_UP) begin
            if (fan < FAN_MAX) fan_next = fan + 1'b1;
          end else begin
            if (fan > FAN_MIN) fan_next = fan - 1'b1;
          end
          if (unit_mode == ST_AUTO) begin
            saved_mode_next = unit_mode;
            unit_mode_next = ST_SENSOR;
          end
          auto_en_next[AF_BLOWER] = 1'b0;
        end
      end
      BTN_TEMP_UP: begin
        if (unit_mode == ST_AUTO || unit_mode == ST_DEF || unit_mode == ST_SENSOR) begin
          if (in_band) temp_up = {1'b0, temp} + (TEMP_W+1)'(1);
          else if (temp < cfg.set_point_top) temp_up = {1'b0, temp} + (TEMP_W+1)'(2);
          else temp_up = {1'b0, temp};
          // Saturate at the top of the field.
          temp_next = temp_up[TEMP_W] ? TEMP_CEIL : temp_up[TEMP_W-1:0];
        end
      end
      BTN_TEMP_DOWN: begin
        if (unit_mode == ST_AUTO || unit_mode == ST_DEF || unit_mode == ST_SENSOR) begin
          if (in_band) begin
            temp_next = temp - 1'b1;
          end else if (temp > cfg.set_point_bottom) begin
            temp_next = (temp >= TEMP_W'(2)) ? temp - TEMP_W'(2) : '0;
          end
        end
      end
      BTN_REAR: begin
        seg_rear_next = 1'b1;
        if (active) rear_next = !rear;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_mode <= ST_OFF;
      saved_mode <= ST_OFF;
      ac <= 1'b0;
      fan <= FAN_MIN;
      recirc <= 1'b0;
      vent <= VENT_FACE;
      temp <= TEMP_RESET;
      rear <= 1'b0;
      seg_rear <= 1'b0;
      seg_mode <= 1'b0;
      auto_en <= 4'hF;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        unit_mode <= unit_mode_next;
        saved_mode <= saved_mode_next;
        ac <= ac_next;
        fan <= fan_next;
        recirc <= recirc_next;
        vent <= vent_next;
        temp <= temp_next;
        rear <= rear_next;
        seg_rear <= seg_rear_next;
        seg_mode <= seg_mode_next;
        auto_en <= auto_en_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status.unit_state <= unit_mode_next;
      status.ac_on <= ac_next;
      status.fan_level <= fan_next;
      status.recirc_on <= recirc_next;
      status.vent_mode <= vent_next;
      status.set_point_half <= temp_next;
      status.rear_defrost_on <= rear_next;
      status.rear_defrost_segment <= seg_rear_next;
      status.mode_segment <= seg_mode_next;
      status.auto_flags <= auto_en_next;
    end
  end

endmodule

>>> rtl/core/climate_panel_button_fsm.sv
`timescale 1ns / 1ps
// Top level of the climate panel button block: APB register file, front end,
// command queue and back end. Depends on cpbf_pkg and the cpbf_* modules.
//
// Each accepted button item yields exactly one panel status item. The block
// sustains one item per clock: the front end accepts a button whenever the
// two-entry command queue has room, and the back end applies one queued
// command per cycle into a registered status output; an item passes through a
// queue slot and then the status register before its status is valid on
// m_tdata. Stalls on the output fill the queue, after which s_tready drops.
// Registers are written through the APB port and should be changed only
// while no item is in flight.
module climate_panel_button_fsm import cpbf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Button stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] button
  // Status stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  // [2:0] unit_state, [3] ac_on, [7:4] fan_level, [8] recirc_on,
  // [11:9] vent_mode, [18:12] set_point_half, [19] rear_defrost_on,
  // [20] rear_defrost_segment, [21] mode_segment, [25:22] auto_flags
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     reg_wr;
  q_wr_t    q_wr;
  q_rd_t    q_rd;
  logic     q_full;
  logic     q_pop;
  status_t  status;

  // Register file: word addressed, upper address bits pick the register.
  assign pready = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fine_band_low <= TEMP_W'(40);
      cfg.fine_band_high <= TEMP_W'(52);
      cfg.set_point_top <= TEMP_W'(65);
      cfg.set_point_bottom <= TEMP_W'(27);
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_FINE_LOW:  cfg.fine_band_low <= pwdata[TEMP_W-1:0];
        REG_FINE_HIGH: cfg.fine_band_high <= pwdata[TEMP_W-1:0];
        REG_SP_TOP:    cfg.set_point_top <= pwdata[TEMP_W-1:0];
        REG_SP_BOTTOM: cfg.set_point_bottom <= pwdata[TEMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register, zero extended.
  always_comb begin
    unique case (reg_idx)
      REG_FINE_LOW:  prdata = {{(32-TEMP_W){1'b0}}, cfg.fine_band_low};
      REG_FINE_HIGH: prdata = {{(32-TEMP_W){1'b0}}, cfg.fine_band_high};
      REG_SP_TOP:    prdata = {{(32-TEMP_W){1'b0}}, cfg.set_point_top};
      REG_SP_BOTTOM: prdata = {{(32-TEMP_W){1'b0}}, cfg.set_point_bottom};
      default:       prdata = '0;
    endcase
  end

  // Classify incoming buttons and push them into the queue.
  cpbf_front u_front (
    .full     (q_full),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .wr       (q_wr)
  );

  // Decouple acceptance from execution.
  cpbf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .pop  (q_pop),
    .rd   (q_rd),
    .full (q_full)
  );

  // Apply commands and hold the status until it is taken.
  cpbf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rd        (q_rd),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status)
  );

  assign m_tdata = {{(OUT_DATA_W-STATUS_W){1'b0}}, status};

  // A command taken by the back end shows up as a valid status next cycle.
  a_pop_emits: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> m_tvalid)
    else $error("popped command produced no status");

  // Input back-pressure only when the queue is really full.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (q_full && q_rd.valid))
    else $error("input stalled with room in the queue");

  // Buttons never drive the unit into diag or ignition-off.
  a_state_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (status.unit_state != ST_DIAG && status.unit_state != ST_IGN_OFF))
    else $error("unit state entered diag or ignition-off");

  // Blower level stays inside its range.
  a_fan_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (status.fan_level >= FAN_MIN && status.fan_level <= FAN_MAX))
    else $error("fan level out of range");

endmodule

>>> sim/climate_panel_button_fsm_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the climate panel button block: button items in,
// panel status items out, predicted and compared here. Depends on cpbf_pkg and
// the RTL under rtl/core.
module climate_panel_button_fsm_test;
  import cpbf_pkg::*;

  // Panel scoreboard: tracks the panel the way the block should, predicts one
  // status item per accepted button and checks the status items in order.
  class panel_scoreboard;
    logic [TEMP_W-1:0] fine_low, fine_high, temp_top, temp_bottom;
    logic [2:0] mode, saved;
    logic compressor, recirc, heater, rear_seg, mode_seg;
    logic [FAN_W-1:0] blower;
    logic [2:0] vent;
    logic [TEMP_W-1:0] temp;
    logic [3:0] enables;
    status_t status_due[$];
    int errors;

    function new();
      fine_low = 7'd40;
      fine_high = 7'd52;
      temp_top = 7'd65;
      temp_bottom = 7'd27;
      mode = ST_OFF;
      saved = ST_OFF;
      compressor = 1'b0;
      blower = FAN_MIN;
      recirc = 1'b0;
      vent = VENT_FACE;
      temp = TEMP_RESET;
      heater = 1'b0;
      rear_seg = 1'b0;
      mode_seg = 1'b0;
      enables = '1;
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void set_band(reg_idx_t idx, logic [TEMP_W-1:0] value);
      case (idx)
        REG_FINE_LOW:  fine_low = value;
        REG_FINE_HIGH: fine_high = value;
        REG_SP_TOP:    temp_top = value;
        REG_SP_BOTTOM: temp_bottom = value;
      endcase
    endfunction

    // Save the state being left unless it is off or ignition-off.
    function void leave_for(logic [2:0] next);
      if (mode != ST_OFF && mode != ST_IGN_OFF) saved = mode;
      mode = next;
    endfunction

    function void defrost_preset();
      compressor = 1'b1;
      blower = FAN_MAX;
      recirc = 1'b0;
      vent = VENT_DEFROST;
    endfunction

    function void note_press(logic [3:0] code);
      logic [2:0] was;
      logic active, steering;
      int t;
      status_t s;
      was = mode;
      active = (mode <= ST_SENSOR);
      steering = (was == ST_AUTO || was == ST_DEF || was == ST_SENSOR);
      case (code)
        BTN_OFF: begin
          if (was != ST_IGN_OFF) begin
            if (was != ST_OFF) leave_for(ST_OFF);
            mode_seg = 1'b0;
          end
          rear_seg = 1'b0;
        end
        BTN_AUTO: begin
          enables = '1;
          rear_seg = 1'b1;
          if (active) leave_for(ST_AUTO);
        end
        BTN_DEFROST: begin
          rear_seg = 1'b1;
          if (was == ST_OFF) begin
            mode = ST_DEF;
            defrost_preset();
          end else if (was == ST_AUTO || was == ST_SENSOR) begin
            leave_for(ST_DEF);
            defrost_preset();
          end else if (was == ST_DEF) begin
            leave_for(saved);
          end
        end
        BTN_AC: begin
          enables[AF_AC] = 1'b0;
          rear_seg = 1'b1;
          if (was == ST_OFF) begin
            leave_for(saved);
            compressor = 1'b1;
          end else if (active) begin
            compressor = ~compressor;
            if (was == ST_AUTO) leave_for(ST_SENSOR);
          end
        end
        BTN_INTAKE: begin
          enables[AF_INTAKE] = 1'b0;
          rear_seg = 1'b1;
          if (active) begin
            recirc = ~recirc;
            if (was == ST_AUTO) leave_for(ST_SENSOR);
          end
        end
        BTN_VENT: begin
          enables[AF_MODE] = 1'b0;
          rear_seg = 1'b1;
          if (active) begin
            if (vent < VENT_DEFROST) vent = vent + 3'd1;
            else if (vent == VENT_DEFROST) vent = VENT_FACE;
            if (was == ST_OFF) mode_seg = 1'b1;
            else if (was == ST_AUTO || was == ST_DEF) leave_for(ST_SENSOR);
          end
        end
        BTN_FAN_UP, BTN_FAN_DOWN: begin
          rear_seg = 1'b1;
          if (was == ST_OFF) begin
            blower = FAN_MIN;
            leave_for(saved);
          end else if (active) begin
            if (code == BTN_FAN_UP) begin
              if (blower < FAN_MAX) blower = blower + 1'b1;
            end else if (blower > FAN_MIN) begin
              blower = blower - 1'b1;
            end
            if (was == ST_AUTO) leave_for(ST_SENSOR);
            enables[AF_BLOWER] = 1'b0;
          end
        end
        BTN_TEMP_UP: begin
          if (steering) begin
            t = temp;
            if (t < fine_high && t > fine_low) t = t + 1;
            else if (t < temp_top) t = t + 2;
            temp = (t > TEMP_CEIL) ? TEMP_CEIL : TEMP_W'(t);
          end
        end
        BTN_TEMP_DOWN: begin
          if (steering) begin
            t = temp;
            if (t > fine_low && t < fine_high) t = t - 1;
            else if (t > temp_bottom) t = (t >= 2) ? t - 2 : 0;
            temp = TEMP_W'(t);
          end
        end
        BTN_REAR: begin
          rear_seg = 1'b1;
          if (active) heater = ~heater;
        end
        default: ;
      endcase
      s = '0;
      s.unit_state = mode;
      s.ac_on = compressor;
      s.fan_level = blower;
      s.recirc_on = recirc;
      s.vent_mode = vent;
      s.set_point_half = temp;
      s.rear_defrost_on = heater;
      s.rear_defrost_segment = rear_seg;
      s.mode_segment = mode_seg;
      s.auto_flags = enables;
      status_due.push_back(s);
    endfunction

    function void check_status(status_t got);
      status_t want;
      string diffs;
      if (status_due.size() == 0) begin
        flag($sformatf("status %h arrived with no press outstanding", got));
        return;
      end
      want = status_due.pop_front();
      diffs = "";
      if (got.unit_state !== want.unit_state)
        diffs = {diffs, $sformatf(" unit_state %0d/%0d", want.unit_state, got.unit_state)};
      if (got.ac_on !== want.ac_on)
        diffs = {diffs, $sformatf(" ac_on %0d/%0d", want.ac_on, got.ac_on)};
      if (got.fan_level !== want.fan_level)
        diffs = {diffs, $sformatf(" fan_level %0d/%0d", want.fan_level, got.fan_level)};
      if (got.recirc_on !== want.recirc_on)
        diffs = {diffs, $sformatf(" recirc_on %0d/%0d", want.recirc_on,
                                  got.recirc_on)};
      if (got.vent_mode !== want.vent_mode)
        diffs = {diffs, $sformatf(" vent_mode %0d/%0d", want.vent_mode, got.vent_mode)};
      if (got.set_point_half !== want.set_point_half)
        diffs = {diffs, $sformatf(" set_point_half %0d/%0d", want.set_point_half,
                                  got.set_point_half)};
      if (got.rear_defrost_on !== want.rear_defrost_on)
        diffs = {diffs, $sformatf(" rear_defrost_on %0d/%0d", want.rear_defrost_on,
                                  got.rear_defrost_on)};
      if (got.rear_defrost_segment !== want.rear_defrost_segment)
        diffs = {diffs, $sformatf(" rear_defrost_segment %0d/%0d", want.rear_defrost_segment,
                                  got.rear_defrost_segment)};
      if (got.mode_segment !== want.mode_segment)
        diffs = {diffs, $sformatf(" mode_segment %0d/%0d", want.mode_segment,
                                  got.mode_segment)};
      if (got.auto_flags !== want.auto_flags)
        diffs = {diffs, $sformatf(" auto_flags %h/%h", want.auto_flags, got.auto_flags)};
      if (diffs != "") flag({"status mismatch, expected/actual:", diffs});
    endfunction
  endclass

  localparam int RUN_LIMIT = 200000;  // cycles before the run is declared hung
  localparam int DRAIN_SLACK = 8;     // well past the status latency
  localparam int LONG_HOLD = 150;     // receiver hold-off that backs up the queue

  localparam int LEAN_NONE = 0;
  localparam int LEAN_UP = 1;
  localparam int LEAN_DOWN = 2;

  // Opening sequence: ignored code, off, fan up, vent and AC from off (fan up and
  // AC restore to a saved off state, vent sets the mode segment), defrost entry and
  // swap, then the buttons from auto, sensor and defrost, and a return from off to sensor.
  localparam btn_t OPENING_RUN [22] = '{
    BTN_NONE, BTN_OFF, BTN_FAN_UP, BTN_VENT, BTN_AC, BTN_DEFROST, BTN_DEFROST,
    BTN_AUTO, BTN_TEMP_UP, BTN_TEMP_DOWN, BTN_FAN_UP, BTN_FAN_DOWN, BTN_INTAKE,
    BTN_REAR, BTN_AC, BTN_VENT, BTN_DEFROST, BTN_TEMP_UP, BTN_DEFROST, BTN_OFF,
    BTN_FAN_DOWN, BTN_REAR
  };

  // Band settings per phase: fine_band_low, fine_band_high, set_point_top,
  // set_point_bottom. Reset values, range extremes, an empty fine band with
  // the set point free to hit both rails, and odd inverted settings.
  localparam int PHASES = 6;
  localparam cfg_t BAND_PLAN [PHASES] = '{
    '{7'd40, 7'd52, 7'd65, 7'd27},
    '{7'd2,  7'd78, 7'd78, 7'd2},
    '{7'd78, 7'd2,  7'd127, 7'd0},
    '{7'd78, 7'd2,  7'd127, 7'd0},
    '{7'd0,  7'd127, 7'd0, 7'd127},
    '{7'd60, 7'd30, 7'd2,  7'd78}
  };
  localparam int PHASE_ITEMS [PHASES] = '{70, 60, 90, 90, 45, 50};
  localparam int PHASE_LEAN [PHASES] = '{LEAN_NONE, LEAN_UP, LEAN_UP, LEAN_DOWN,
                                         LEAN_NONE, LEAN_NONE};

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;              // [3:0] button
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // status_t fields, unit_state lowest
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  panel_scoreboard sb = new();
  int hold_req = 0;                 // cycles the receiver still has to hold off
  int unsigned cycle_count = 0;

  climate_panel_button_fsm i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a correct run ends far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sample both handshakes on the rising edge. Note the press before the
  // status check so a status arriving in the same cycle as its press would still find its expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_press(s_tdata[3:0]);
      if (m_tvalid && m_tready) sb.check_status(status_t'(m_tdata[STATUS_W-1:0]));
    end
  end

  // Receiver: switch stall style after each span of random length (always ready, coin
  // flip, mostly stalled, alternating) and honor long hold-off requests.
  initial begin
    int style;
    int span;
    forever begin
      style = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk);
        if (hold_req > 0) begin
          m_tready <= 1'b0;
          hold_req--;
        end else begin
          case (style)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
          endcase
        end
      end
    end
  end

  // Offer one button from a falling edge and hold it until accepted; return
  // at the falling edge after acceptance with tvalid still high.
  task automatic send_button(input logic [3:0] code);
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, code};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Write one band register, then read it back. Start and end at a falling edge.
  task automatic write_reg(input reg_idx_t idx, input logic [TEMP_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_band(idx, value);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[TEMP_W-1:0] !== value)
      sb.flag($sformatf("register %s read %h, wrote %h", idx.name(), prdata, value));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Pick a button; a lean toward temp up or down drives the set point to its rails.
  function automatic logic [3:0] pick_button(input int lean);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 4'($urandom_range(BTN_REAR + 1, BTN_NONE));
    if (lean == LEAN_UP && r < 75) return BTN_TEMP_UP;
    if (lean == LEAN_DOWN && r < 75) return BTN_TEMP_DOWN;
    return 4'($urandom_range(BTN_OFF, BTN_REAR));
  endfunction

  // Random presses in bursts with random gaps; ignored codes do not count.
  task automatic run_presses(input int count, input int lean);
    int sent;
    int burst;
    int gap;
    logic [3:0] code;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < count) begin
          code = pick_button(lean);
          send_button(code);
          if (code <= BTN_REAR) sent++;
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every predicted status has come back, then let the pipe settle.
  task automatic drain();
    while (sb.status_due.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening under the reset band settings, back to back.
    foreach (OPENING_RUN[k]) send_button(OPENING_RUN[k]);
    for (int c = BTN_REAR + 1; c < BTN_NONE; c++) send_button(4'(c));
    s_tvalid <= 1'b0;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_FINE_LOW, BAND_PLAN[p].fine_band_low);
      write_reg(REG_FINE_HIGH, BAND_PLAN[p].fine_band_high);
      write_reg(REG_SP_TOP, BAND_PLAN[p].set_point_top);
      write_reg(REG_SP_BOTTOM, BAND_PLAN[p].set_point_bottom);
      // Hold the receiver off while presses keep coming: fill the queue.
      if (p == 0) hold_req = LONG_HOLD;
      run_presses(PHASE_ITEMS[p], PHASE_LEAN[p]);
      drain();
    end

    if (sb.errors == 0 && sb.status_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
